/* src/wsr_pkg.sv */
`default_nettype none
package wsr_pkg;

    // register map
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam logic [CFG_IDX_W-1:0] REG_IN_RATE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_RATE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IN_CHANNELS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_CHANNELS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAMES   = 3'd4;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int RATE_W   = 18;
    localparam int CHAN_W   = 2;
    localparam int FRAMES_W = 16;
    localparam int FIN_W    = 32;
    localparam int COEF_W   = 17;
    localparam int RES_W    = 6;
    localparam logic [RES_W-1:0] MAX_RES = 6'd40;
    localparam logic [CHAN_W-1:0] CHAN_MONO = 2'd1;

    // reset values of the registers
    localparam logic [RATE_W-1:0]   RST_RATE     = 18'd44100;
    localparam logic [CHAN_W-1:0]   RST_CHANNELS = 2'd2;
    localparam logic [FRAMES_W-1:0] RST_MAX      = 16'd65535;

    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint          ONE_Q30 = 64'sd1073741824;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;

    // unsigned quotient by shift and subtract, for the constant tables
    function automatic longint unsigned udiv(longint unsigned n, longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], n[b]};
            if (r >= d)
            begin
                r    = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // signed quotient truncated toward zero
    function automatic longint sdiv(longint n, longint unsigned d);
        longint unsigned mag;
        mag = (n < 0) ? longint'(-n) : longint'(n);
        return (n < 0) ? -longint'(udiv(mag, d)) : longint'(udiv(mag, d));
    endfunction

    // sin(pi*num/den) in Q30, taylor series on the reduced angle
    function automatic longint sinpi_q30(longint unsigned num, longint unsigned den);
        longint unsigned r;
        logic            neg;
        longint          a;
        longint          a2;
        longint          term;
        longint          sum;
        r   = num - udiv(num, 2 * den) * (2 * den);
        neg = 1'b0;
        if (r >= den)
        begin
            neg = 1'b1;
            r   = r - den;
        end
        if (2 * r > den)
        begin
            r = den - r;
        end
        a    = longint'(udiv(r * PI_Q30, den));
        a2   = (a * a) >>> 30;
        term = a;
        sum  = a;
        for (int k = 1; k <= 7; k++)
        begin
            term = sdiv((term * a2) >>> 30, (2 * k) * (2 * k + 1));
            sum  = (k % 2 == 1) ? sum - term : sum + term;
        end
        return neg ? -sum : sum;
    endfunction

    // sinc(num/den) in Q30
    function automatic longint sinc_q30(longint num, longint unsigned den);
        longint unsigned mag;
        longint          s;
        longint unsigned px;
        longint unsigned m;
        longint          q;
        if (num == 0)
        begin
            return ONE_Q30;
        end
        mag = longint'(num < 0 ? -num : num);
        s   = sinpi_q30(mag, den);
        px  = udiv(mag * PI_Q30, den);
        m   = longint'(s < 0 ? -s : s);
        q   = longint'(udiv(m << 30, px));
        return (s < 0) ? -q : q;
    endfunction

    // signed q2.15 filter weight: sinc times hann, halves rounded away from zero
    function automatic coef_t coef_value(int t, int p, int taps, int phases);
        longint          c;
        longint          w;
        longint          x;
        longint          prod;
        longint unsigned m;
        c    = sinpi_q30(longint'(2 * t + taps), longint'(2 * taps));
        w    = (ONE_Q30 - c) / 2;
        x    = longint'((t - taps) * phases - p);
        prod = sinc_q30(x, longint'(phases)) * w;
        m    = longint'(prod < 0 ? -prod : prod);
        m    = (m + (64'd1 << 44)) >> 45;
        return (prod < 0) ? -coef_t'(m) : coef_t'(m);
    endfunction

endpackage
`default_nettype wire

/* src/wsr_if.sv */
`default_nettype none
interface wsr_in_if;
    import wsr_pkg::*;
    logic    valid;
    logic    ready;
    sample_t sample_left;
    sample_t sample_right;
    logic    block_end;
    modport source (output valid, output sample_left, output sample_right,
                    output block_end, input ready);
    modport sink (input valid, input sample_left, input sample_right,
                  input block_end, output ready);
endinterface

interface wsr_out_if;
    import wsr_pkg::*;
    logic    valid;
    logic    ready;
    sample_t out_left;
    sample_t out_right;
    logic    final_frame;
    modport source (output valid, output out_left, output out_right,
                    output final_frame, input ready);
    modport sink (input valid, input out_left, input out_right,
                  input final_frame, output ready);
endinterface
`default_nettype wire

/* src/windowed_sinc_resampler.sv */
// Sequence: an equal-rate copy is taken in the idle state and written to the output
//   register from the copy state once the output is free; a filtered output goes through
//   position product, 34-step quotient, 6 phase steps (at the defaults), tap pass, convert, push.
// Flow: one request at a time, as a new frame is taken only back in the idle state; each
//   filtered output can be held by output stalls.
// Reset: rst_n sets the configuration registers to their defaults, clears the sequencer
//   and empties the delay line counts; the delay line memory itself needs no clearing pass.
`default_nettype none
module windowed_sinc_resampler #(
    parameter int TAPS_EACH_SIDE = 4,
    parameter int PHASES         = 64,
    parameter int MAX_UPSAMPLE   = 8,
    parameter int MAX_CHANNELS   = 2
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    wsr_in_if.sink                            in_ch,
    wsr_out_if.source                         out_ch,
    input  wire logic                         cfg_we,
    input  wire logic [wsr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [wsr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import wsr_pkg::*;

    localparam int NTAPS  = 2 * TAPS_EACH_SIDE + 1;
    localparam int AW     = (NTAPS > 1) ? $clog2(NTAPS) : 1;
    localparam int PBW    = $clog2(PHASES);
    localparam int PMW    = $clog2(PHASES + 1);
    localparam int ROM_N  = PHASES * NTAPS;
    localparam int ROM_AW = $clog2(ROM_N);
    localparam int TW     = $clog2(NTAPS + 3);
    localparam int UPW    = $clog2(MAX_UPSAMPLE + 1);
    localparam int QW     = FRAMES_W + RATE_W;
    localparam int CW     = $clog2(QW + 1);
    localparam int IDXW   = QW + 2;
    localparam int PROD_W = SAMPLE_W + COEF_W;
    localparam int ACC_W  = PROD_W + $clog2(NTAPS) + 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_COPY = 4'd1;
    localparam logic [3:0] S_LOOP = 4'd2;
    localparam logic [3:0] S_MULR = 4'd3;
    localparam logic [3:0] S_DIV  = 4'd4;
    localparam logic [3:0] S_CHK  = 4'd5;
    localparam logic [3:0] S_PH   = 4'd6;
    localparam logic [3:0] S_TAP  = 4'd7;
    localparam logic [3:0] S_CONV = 4'd8;
    localparam logic [3:0] S_PUSH = 4'd9;
    localparam logic [3:0] S_FIN  = 4'd10;

    typedef coef_t coef_rom_t [ROM_N];

    function automatic coef_rom_t build_rom();
        coef_rom_t rom;
        for (int p = 0; p < PHASES; p++)
        begin
            for (int t = 0; t < NTAPS; t++)
            begin
                rom[p * NTAPS + t] = coef_value(t, p, TAPS_EACH_SIDE, PHASES);
            end
        end
        return rom;
    endfunction

    localparam coef_rom_t COEF_ROM = build_rom();

    // clamp to +-1.0 in q30, scale by 32767 and truncate toward zero
    function automatic sample_t to_out(logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] c;
        logic [30:0]             mag;
        logic [45:0]             prod;
        logic [14:0]             m;
        c = acc;
        if (acc > ACC_W'(ONE_Q30))
        begin
            c = ACC_W'(ONE_Q30);
        end
        else if (acc < -ACC_W'(ONE_Q30))
        begin
            c = -ACC_W'(ONE_Q30);
        end
        mag  = c[ACC_W-1] ? 31'(-c) : 31'(c);
        prod = 46'(mag) * 46'd32767;
        m    = prod[44:30];
        return c[ACC_W-1] ? -sample_t'({1'b0, m}) : sample_t'({1'b0, m});
    endfunction

    // configuration registers
    logic [RATE_W-1:0]   in_rate_reg;
    logic [RATE_W-1:0]   out_rate_reg;
    logic [CHAN_W-1:0]   in_chan_reg;
    logic [CHAN_W-1:0]   out_chan_reg;
    logic [FRAMES_W-1:0] max_reg;

    // block state and sequencer
    logic [3:0]          state_reg;
    logic [FIN_W-1:0]    fin_reg;
    logic [FRAMES_W-1:0] fo_reg;
    logic [RES_W-1:0]    n_reg;
    logic                end_reg;
    sample_t             smp_l_reg;
    sample_t             smp_r_reg;
    logic [AW-1:0]       newest_reg;

    // position arithmetic
    logic [QW-1:0]             pp_reg;
    logic [FIN_W+RATE_W-1:0]   fmul_reg;
    logic [QW-1:0]             whole_reg;
    logic [RATE_W-1:0]         rem_reg;
    logic [PBW-1:0]            ph_reg;
    logic [RATE_W-1:0]         div_rem_reg;
    logic [QW-1:0]             div_q_reg;
    logic [CW-1:0]             div_cnt_reg;

    // tap pipeline
    logic [TW-1:0]             tap_reg;
    logic                      s1_valid_reg;
    logic                      s2_valid_reg;
    coef_t                     coef_reg;
    logic [2*SAMPLE_W-1:0]     hist_rd_reg;
    logic signed [PROD_W-1:0]  prod0_reg;
    logic signed [PROD_W-1:0]  prod1_reg;
    logic signed [ACC_W-1:0]   acc0_reg;
    logic signed [ACC_W-1:0]   acc1_reg;

    // result and held result for a block end
    sample_t res_l_reg;
    sample_t res_r_reg;
    logic    held_valid_reg;
    sample_t held_l_reg;
    sample_t held_r_reg;
    logic    held_final_reg;

    // output register
    logic    out_valid_reg;
    sample_t out_l_reg;
    sample_t out_r_reg;
    logic    out_final_reg;

    // delay line memory, both channels in one word
    logic [2*SAMPLE_W-1:0] hist_mem [NTAPS];

    // effective rates and channel modes
    logic [RATE_W-1:0]     ir;
    logic [RATE_W-1:0]     orr_raw;
    logic [RATE_W+UPW-1:0] ir_up;
    logic [RATE_W-1:0]     orr;
    logic                  in_st;
    logic                  out_st;
    logic                  copy_mode;

    assign ir        = (in_rate_reg == '0) ? RATE_W'(1) : in_rate_reg;
    assign orr_raw   = (out_rate_reg == '0) ? RATE_W'(1) : out_rate_reg;
    assign ir_up     = (RATE_W + UPW)'(ir) * (RATE_W + UPW)'(MAX_UPSAMPLE);
    assign orr       = ((RATE_W + UPW)'(orr_raw) > ir_up) ? RATE_W'(ir_up) : orr_raw;
    assign in_st     = (in_chan_reg != CHAN_MONO) && (MAX_CHANNELS >= 2);
    assign out_st    = (out_chan_reg != CHAN_MONO) && (MAX_CHANNELS >= 2);
    assign copy_mode = (ir == orr_raw) && (in_st == out_st);

    logic in_fire;
    logic out_free;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;

    // the output register takes a new frame this cycle
    logic out_load;
    assign out_load = out_free && (((state_reg == S_COPY) && (fo_reg < max_reg))
                      || ((state_reg == S_PUSH) && (!end_reg || held_valid_reg))
                      || ((state_reg == S_FIN) && end_reg && held_valid_reg));

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.out_left    = out_l_reg;
    assign out_ch.out_right   = out_r_reg;
    assign out_ch.final_frame = out_final_reg;

    // write address of the next frame
    logic [AW-1:0] wr_addr;
    assign wr_addr = (newest_reg == AW'(NTAPS - 1)) ? '0 : newest_reg + AW'(1);

    // one restoring divider step
    logic [RATE_W:0]   div_trial;
    logic              div_ge;
    logic [RATE_W-1:0] div_rem_step;
    assign div_trial    = {div_rem_reg, div_q_reg[QW-1]};
    assign div_ge       = div_trial >= {1'b0, orr};
    assign div_rem_step = div_ge ? RATE_W'(div_trial - {1'b0, orr}) : RATE_W'(div_trial);

    // phase dividend rem*PHASES
    logic [RATE_W+PMW-1:0] ph_dividend;
    assign ph_dividend = (RATE_W + PMW)'(rem_reg) * (RATE_W + PMW)'(PHASES);

    // tap address and range checks
    logic signed [IDXW-1:0] tap_idx;
    logic signed [IDXW-1:0] tap_age;
    logic                   tap_ok;
    logic signed [AW+1:0]   tap_slot;
    logic [AW-1:0]          tap_addr;
    logic [ROM_AW-1:0]      rom_addr;

    assign tap_idx = $signed({2'b00, whole_reg}) + IDXW'(tap_reg)
                     - IDXW'(TAPS_EACH_SIDE);
    assign tap_age = $signed(IDXW'(fin_reg)) - IDXW'(1) - tap_idx;
    assign tap_ok  = (tap_reg < TW'(NTAPS)) && (tap_idx >= 0)
                     && (tap_idx < $signed(IDXW'(fin_reg)))
                     && (tap_age <= IDXW'(NTAPS - 1));
    assign tap_slot = $signed({2'b00, newest_reg}) - $signed((AW + 2)'(tap_age[AW:0]));
    assign tap_addr = (tap_slot < 0) ? AW'(tap_slot + (AW + 2)'(NTAPS)) : AW'(tap_slot);
    assign rom_addr = ROM_AW'(ph_reg) * ROM_AW'(NTAPS) + ROM_AW'(tap_reg);

    logic res_final;
    assign res_final = ({1'b0, fo_reg} + 17'd1) == {1'b0, max_reg};

    // delay line write and registered read
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            hist_mem[wr_addr] <= {(in_st ? in_ch.sample_right : sample_t'(0)),
                                  in_ch.sample_left};
        end
        hist_rd_reg <= hist_mem[tap_addr];
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_rate_reg  <= RST_RATE;
            out_rate_reg <= RST_RATE;
            in_chan_reg  <= RST_CHANNELS;
            out_chan_reg <= RST_CHANNELS;
            max_reg      <= RST_MAX;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IN_RATE:      in_rate_reg  <= cfg_data;
                REG_OUT_RATE:     out_rate_reg <= cfg_data;
                REG_IN_CHANNELS:  in_chan_reg  <= cfg_data[CHAN_W-1:0];
                REG_OUT_CHANNELS: out_chan_reg <= cfg_data[CHAN_W-1:0];
                REG_MAX_FRAMES:   max_reg      <= cfg_data[FRAMES_W-1:0];
                default:          ;
            endcase
        end
    end

    // payload registers of the datapath
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            smp_l_reg <= in_ch.sample_left;
            smp_r_reg <= in_ch.sample_right;
        end
        coef_reg  <= COEF_ROM[rom_addr];
        prod0_reg <= $signed(hist_rd_reg[SAMPLE_W-1:0]) * coef_reg;
        prod1_reg <= $signed(hist_rd_reg[2*SAMPLE_W-1:SAMPLE_W]) * coef_reg;
        if (state_reg == S_LOOP)
        begin
            pp_reg   <= QW'(fo_reg) * QW'(ir);
            fmul_reg <= (FIN_W + RATE_W)'(fin_reg) * (FIN_W + RATE_W)'(orr);
        end
        if (state_reg == S_CONV)
        begin
            res_l_reg <= to_out(acc0_reg);
            res_r_reg <= out_st ? (in_st ? to_out(acc1_reg) : to_out(acc0_reg))
                                : sample_t'(0);
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fin_reg        <= '0;
            fo_reg         <= '0;
            n_reg          <= '0;
            end_reg        <= 1'b0;
            newest_reg     <= AW'(NTAPS - 1);
            whole_reg      <= '0;
            rem_reg        <= '0;
            ph_reg         <= '0;
            div_rem_reg    <= '0;
            div_q_reg      <= '0;
            div_cnt_reg    <= '0;
            tap_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            acc0_reg       <= '0;
            acc1_reg       <= '0;
            held_valid_reg <= 1'b0;
            held_l_reg     <= '0;
            held_r_reg     <= '0;
            held_final_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_l_reg      <= '0;
            out_r_reg      <= '0;
            out_final_reg  <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                // take a frame into the delay line
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        newest_reg <= wr_addr;
                        fin_reg    <= fin_reg + FIN_W'(1);
                        end_reg    <= in_ch.block_end;
                        n_reg      <= '0;
                        state_reg  <= copy_mode ? S_COPY : S_LOOP;
                    end
                end
                // equal rates and channel modes, copy the frame
                S_COPY:
                begin
                    if (fo_reg >= max_reg)
                    begin
                        state_reg <= S_FIN;
                    end
                    else if (out_free)
                    begin
                        out_l_reg     <= smp_l_reg;
                        out_r_reg     <= out_st ? smp_r_reg : sample_t'(0);
                        out_final_reg <= res_final || end_reg;
                        fo_reg        <= fo_reg + FRAMES_W'(1);
                        state_reg     <= S_FIN;
                    end
                end
                // next output, position products
                S_LOOP:
                begin
                    state_reg <= (n_reg < MAX_RES && fo_reg < max_reg) ? S_MULR : S_FIN;
                end
                // enough input for this output, start the quotient
                S_MULR:
                begin
                    if ((FIN_W + RATE_W)'(pp_reg) + (FIN_W + RATE_W)'(ir) > fmul_reg)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        div_rem_reg <= '0;
                        div_q_reg   <= pp_reg;
                        div_cnt_reg <= CW'(QW);
                        state_reg   <= S_DIV;
                    end
                end
                // whole and remainder of the position
                S_DIV:
                begin
                    div_rem_reg <= div_rem_step;
                    div_q_reg   <= {div_q_reg[QW-2:0], div_ge};
                    div_cnt_reg <= div_cnt_reg - CW'(1);
                    if (div_cnt_reg == CW'(1))
                    begin
                        whole_reg <= {div_q_reg[QW-2:0], div_ge};
                        rem_reg   <= div_rem_step;
                        state_reg <= S_CHK;
                    end
                end
                // right-hand taps present or block end, start the phase quotient
                S_CHK:
                begin
                    if (!end_reg && ((QW + 1)'(whole_reg) + (QW + 1)'(TAPS_EACH_SIDE + 1)
                                     > (QW + 1)'(fin_reg)))
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        div_rem_reg <= RATE_W'(ph_dividend >> PBW);
                        div_q_reg   <= {ph_dividend[PBW-1:0], (QW - PBW)'(0)};
                        div_cnt_reg <= CW'(PBW);
                        state_reg   <= S_PH;
                    end
                end
                // phase bits
                S_PH:
                begin
                    div_rem_reg <= div_rem_step;
                    div_q_reg   <= {div_q_reg[QW-2:0], div_ge};
                    div_cnt_reg <= div_cnt_reg - CW'(1);
                    if (div_cnt_reg == CW'(1))
                    begin
                        ph_reg       <= PBW'({div_q_reg[QW-2:0], div_ge});
                        tap_reg      <= '0;
                        s1_valid_reg <= 1'b0;
                        s2_valid_reg <= 1'b0;
                        acc0_reg     <= '0;
                        acc1_reg     <= '0;
                        state_reg    <= S_TAP;
                    end
                end
                // read, multiply, accumulate one tap a cycle
                S_TAP:
                begin
                    s1_valid_reg <= tap_ok;
                    s2_valid_reg <= s1_valid_reg;
                    if (s2_valid_reg)
                    begin
                        acc0_reg <= acc0_reg + ACC_W'(prod0_reg);
                        acc1_reg <= acc1_reg + ACC_W'(prod1_reg);
                    end
                    tap_reg <= tap_reg + TW'(1);
                    if (tap_reg == TW'(NTAPS + 2))
                    begin
                        state_reg <= S_CONV;
                    end
                end
                S_CONV:
                begin
                    state_reg <= S_PUSH;
                end
                // hand the result out, or hold it back for the block end mark
                S_PUSH:
                begin
                    if (!end_reg || held_valid_reg)
                    begin
                        if (out_free)
                        begin
                            out_l_reg     <= end_reg ? held_l_reg : res_l_reg;
                            out_r_reg     <= end_reg ? held_r_reg : res_r_reg;
                            out_final_reg <= end_reg ? held_final_reg : res_final;
                            held_l_reg     <= res_l_reg;
                            held_r_reg     <= res_r_reg;
                            held_final_reg <= res_final;
                            fo_reg        <= fo_reg + FRAMES_W'(1);
                            n_reg         <= n_reg + RES_W'(1);
                            state_reg     <= S_LOOP;
                        end
                    end
                    else
                    begin
                        held_valid_reg <= 1'b1;
                        held_l_reg     <= res_l_reg;
                        held_r_reg     <= res_r_reg;
                        held_final_reg <= res_final;
                        fo_reg         <= fo_reg + FRAMES_W'(1);
                        n_reg          <= n_reg + RES_W'(1);
                        state_reg      <= S_LOOP;
                    end
                end
                // release the held result and clear the block on its end
                S_FIN:
                begin
                    if (!end_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (!held_valid_reg || out_free)
                    begin
                        if (held_valid_reg)
                        begin
                            out_l_reg     <= held_l_reg;
                            out_r_reg     <= held_r_reg;
                            out_final_reg <= 1'b1;
                        end
                        held_valid_reg <= 1'b0;
                        fin_reg        <= '0;
                        fo_reg         <= '0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // no result may be held back while a new frame can come in
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !held_valid_reg)
        else $error("held result left over at idle");

    // per-request result count stays within its bound
    assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= MAX_RES)
        else $error("result count overrun");

    // the divider only runs in its two states
    assert property (@(posedge clk) disable iff (!rst_n)
        (div_cnt_reg != '0) |-> (state_reg == S_DIV || state_reg == S_PH))
        else $error("divider active outside its states");

    // phase stays inside the table
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TAP) |-> (ph_reg < PBW'(PHASES - 1) || ph_reg == PBW'(PHASES - 1)))
        else $error("phase out of range");

    // a block end request leaves the frame count cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && end_reg && !held_valid_reg) |=> (fin_reg == '0))
        else $error("block end did not clear the frame count");
`endif

endmodule
`default_nettype wire
